// File: hw/rtl/dtcs_pkg.sv
package dtcs_pkg;

   localparam int SCREEN_WIDTH = 256;
   localparam int SCREEN_HEIGHT = 256;
   localparam int PIXEL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int PIX_W = $clog2(PIXEL_COUNT);

   localparam int CELL_STEPS = 24;
   localparam int FADE_STEPS = 16;
   localparam int STEP_W = 5;
   localparam int LEVEL_SHIFT = 12;
   localparam int FADE_ONE_BIT = 28;

   localparam logic [1:0] OP_PLOT = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [1:0] CSR_ATTENUATION = 2'd0;
   localparam logic [1:0] CSR_LIGHT = 2'd1;
   localparam logic [1:0] CSR_DARK = 2'd2;
   localparam logic [1:0] CSR_CELL = 2'd3;

   localparam logic [15:0] ATTENUATION_RESET = 16'd6554;
   localparam logic [15:0] LIGHT_RESET = 16'd58982;
   localparam logic [15:0] DARK_RESET = 16'd13107;
   localparam logic [23:0] CELL_RESET = 24'd6434;

   typedef struct packed {
      logic [1:0]  operation;
      logic [23:0] tex_u;
      logic [23:0] tex_v;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [31:0] fragment_depth;
   } req_type;

   typedef struct packed {
      logic        was_written;
      logic [15:0] pixel_shade;
      logic [31:0] stored_depth;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear_write;
      logic fetch;
      logic cell_step;
      logic fade_init;
      logic fade_step;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_clear;
      logic op_plot;
      logic clear_last;
      logic cell_last;
      logic fade_last;
   } ctl_sts_type;

   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_CELL,
      ST_LEVEL,
      ST_FADE,
      ST_CLEAR,
      ST_COMMIT
   } state_type;

endpackage

// File: hw/rtl/dtcs_ctrl.sv
module dtcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dtcs_pkg::ctl_sts_type sts,
   output dtcs_pkg::ctl_cmd_type cmd
);
   import dtcs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            if (sts.op_clear) begin
               state_in = ST_CLEAR;
            end else if (sts.op_plot) begin
               state_in = ST_CELL;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_CELL: begin
            cmd.cell_step = 1'b1;
            if (sts.cell_last) state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.fade_init = 1'b1;
            state_in = ST_FADE;
         end
         ST_FADE: begin
            cmd.fade_step = 1'b1;
            if (sts.fade_last) state_in = ST_COMMIT;
         end
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/dtcs_datapath.sv
module dtcs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dtcs_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   output dtcs_pkg::rsp_type     rsp_payload,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   input  dtcs_pkg::ctl_cmd_type cmd,
   output dtcs_pkg::ctl_sts_type sts
);
   import dtcs_pkg::*;

   logic [15:0] gain_ff, light_ff, dark_ff;
   logic [23:0] cell_ff, cell_eff;

   req_type           req_ff;
   logic [PIX_W-1:0]  addr_ff, addr_in, clr_cnt_ff;
   logic              in_range_ff, in_range_in;
   logic [47:0]       mem [PIXEL_COUNT];
   logic [47:0]       rd_ff;
   logic [31:0]       rd_depth;
   logic [15:0]       rd_shade;

   logic [STEP_W-1:0] step_ff;
   logic [23:0]       nu_ff, nv_ff, ru_ff, rv_ff;
   logic [24:0]       ru_sh, rv_sh, ru_nx, rv_nx;
   logic              ru_ge, rv_ge, qu_ff, qv_ff;

   logic [47:0]       prod;
   logic [48:0]       denom_ff;
   logic [48:0]       fr_ff;
   logic [49:0]       fr_sh, fr_nx;
   logic              fr_ge;
   logic [15:0]       q_ff, level;

   logic              pass;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= ATTENUATION_RESET;
         light_ff <= LIGHT_RESET;
         dark_ff  <= DARK_RESET;
         cell_ff  <= CELL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTENUATION: gain_ff  <= csr_wdata[15:0];
            CSR_LIGHT:       light_ff <= csr_wdata[15:0];
            CSR_DARK:        dark_ff  <= csr_wdata[15:0];
            CSR_CELL:        cell_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cell_eff = (cell_ff == '0) ? 24'd1 : cell_ff;

   assign addr_in = PIX_W'(32'(req_payload.pixel_y) * 32'(SCREEN_WIDTH)
                           + 32'(req_payload.pixel_x));
   assign in_range_in = (32'(req_payload.pixel_x) < 32'(SCREEN_WIDTH))
                     && (32'(req_payload.pixel_y) < 32'(SCREEN_HEIGHT));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_payload;
         addr_ff     <= addr_in;
         in_range_ff <= in_range_in;
      end
   end

   assign rd_depth = rd_ff[47:16];
   assign rd_shade = rd_ff[15:0];
   assign pass = (req_ff.operation == OP_PLOT) && in_range_ff
              && (req_ff.fragment_depth < rd_depth);

   // frame store: depth in the upper 32 bits, shade in the lower 16
   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         mem[clr_cnt_ff] <= {32'hFFFF_FFFF, 16'h0000};
      end else if (cmd.commit && pass) begin
         mem[addr_ff] <= {req_ff.fragment_depth, q_ff};
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // cell index parity: two restoring dividers sharing the divisor
   assign ru_sh = {ru_ff, nu_ff[23]};
   assign rv_sh = {rv_ff, nv_ff[23]};
   assign ru_ge = ru_sh >= {1'b0, cell_eff};
   assign rv_ge = rv_sh >= {1'b0, cell_eff};
   assign ru_nx = ru_ge ? ru_sh - {1'b0, cell_eff} : ru_sh;
   assign rv_nx = rv_ge ? rv_sh - {1'b0, cell_eff} : rv_sh;

   // fade: one quotient bit a step, remainder stays below the denominator
   assign prod  = 48'(gain_ff) * 48'(req_ff.fragment_depth);
   assign fr_sh = {fr_ff, 1'b0};
   assign fr_ge = fr_sh >= {1'b0, denom_ff};
   assign fr_nx = fr_ge ? fr_sh - {1'b0, denom_ff} : fr_sh;
   assign level = (qu_ff ^ qv_ff) ? dark_ff : light_ff;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         denom_ff <= 49'(prod) + (49'(1) << FADE_ONE_BIT);
         nu_ff    <= req_ff.tex_u;
         nv_ff    <= req_ff.tex_v;
         ru_ff    <= '0;
         rv_ff    <= '0;
      end else if (cmd.cell_step) begin
         nu_ff <= {nu_ff[22:0], 1'b0};
         nv_ff <= {nv_ff[22:0], 1'b0};
         ru_ff <= ru_nx[23:0];
         rv_ff <= rv_nx[23:0];
         qu_ff <= ru_ge;
         qv_ff <= rv_ge;
      end
      if (cmd.fade_init) begin
         fr_ff <= 49'(level) << LEVEL_SHIFT;
      end else if (cmd.fade_step) begin
         fr_ff <= fr_nx[48:0];
         q_ff  <= {q_ff[14:0], fr_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load || cmd.fade_init) begin
         step_ff <= '0;
      end else if (cmd.cell_step || cmd.fade_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
      if (cmd.commit) begin
         if ((req_ff.operation == OP_CLEAR) || !in_range_ff) begin
            rsp_ff <= '{was_written: 1'b0, pixel_shade: '0, stored_depth: '1};
         end else if (pass) begin
            rsp_ff <= '{was_written: 1'b1, pixel_shade: q_ff,
                        stored_depth: req_ff.fragment_depth};
         end else begin
            rsp_ff <= '{was_written: 1'b0, pixel_shade: rd_shade,
                        stored_depth: rd_depth};
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.op_clear   = req_ff.operation == OP_CLEAR;
   assign sts.op_plot    = (req_ff.operation == OP_PLOT) && in_range_ff;
   assign sts.clear_last = clr_cnt_ff == '1;
   assign sts.cell_last  = step_ff == STEP_W'(CELL_STEPS - 1);
   assign sts.fade_last  = step_ff == STEP_W'(FADE_STEPS - 1);

endmodule

// File: hw/rtl/depth_tested_checker_shader.sv
// Z-buffered checker shader over a 256 x 256 frame. A command transfers at
// a rising edge with start high and busy low; its single result appears on
// rsp_payload for exactly one cycle with rsp_valid high and cannot be held
// off, so capture it on that cycle. A read or a spare opcode passes through
// the fetch state and the commit state before its registered result strobe;
// a plot passes through the fetch state, a 24-step restoring divide for the
// checker cell parity (u and v in parallel), a level select state, a 16-step
// divide for the distance fade and the commit state; a clear frame passes
// through the fetch state, a sweep of one pixel per cycle through the frame
// store and the commit state. Busy is low again in the strobe cycle.
// After reset the same sweep runs through the frame store with busy high
// before the first command is taken. Configuration writes through
// csr_we/csr_index/csr_wdata take effect at once and belong only in idle
// time.
module depth_tested_checker_shader (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dtcs_pkg::req_type req_payload,
   output logic              rsp_valid,
   output dtcs_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import dtcs_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequence each command: fetch, then divide for a plot or sweep the frame for a clear, then commit
   dtcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // hold the frame store, config registers, dividers and result register
   dtcs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// File: hw/rtl/dtcs_checker.sv
module dtcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input dtcs_pkg::rsp_type rsp_payload
);
   import dtcs_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a transfer");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_written_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.was_written) |-> (rsp_payload.stored_depth != '1))
      else $error("maximum depth reported as written");

endmodule

bind depth_tested_checker_shader dtcs_checker u_dtcs_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

// File: bench/depth_tested_checker_shader_tb.sv
module depth_tested_checker_shader_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtcs_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   depth_tested_checker_shader dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the frame stores and the shading registers.
   logic [31:0] depth_shadow [PIXEL_COUNT];
   logic [15:0] shade_shadow [PIXEL_COUNT];
   logic [15:0] fade_gain;
   logic [15:0] light_shade;
   logic [15:0] dark_shade;
   logic [23:0] checker_cell;

   req_type fragments_pending [$];
   rsp_type pixels_expected [$];
   int      transfers_done;
   int      mismatches;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void clear_shadow_frame();
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         depth_shadow[i] = '1;
         shade_shadow[i] = '0;
      end
   endfunction

   // Compute the result of one command and advance the shadow stores.
   function automatic rsp_type shade_fragment(req_type frag);
      rsp_type     res;
      int          pix;
      logic [23:0] cell_div;
      logic [15:0] level;
      logic [63:0] denom;
      logic [63:0] quot;
      res.was_written  = 1'b0;
      res.pixel_shade  = '0;
      res.stored_depth = '1;
      if (frag.operation == OP_CLEAR) begin
         clear_shadow_frame();
      end else begin
         pix = int'(frag.pixel_y) * SCREEN_WIDTH + int'(frag.pixel_x);
         if (frag.operation == OP_PLOT && frag.fragment_depth < depth_shadow[pix]) begin
            cell_div = (checker_cell == 0) ? 24'd1 : checker_cell;
            level = (((frag.tex_u / cell_div) + (frag.tex_v / cell_div)) & 1) ? dark_shade
                                                                               : light_shade;
            denom = (64'd1 << 28) + 64'(fade_gain) * 64'(frag.fragment_depth);
            quot  = (64'(level) << 28) / denom;
            depth_shadow[pix] = frag.fragment_depth;
            shade_shadow[pix] = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
            res.was_written = 1'b1;
         end
         res.pixel_shade  = shade_shadow[pix];
         res.stored_depth = depth_shadow[pix];
      end
      return res;
   endfunction

   // Driver: hold start until the transfer, then take the next command,
   // idling at the rate of the current phase.
   always @(posedge clock) begin
      logic go;
      int   idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && !busy) begin
            pixels_expected.push_back(shade_fragment(req_payload));
            transfers_done++;
            go = 1'b0;
         end
         idle_pct = (transfers_done < 700) ? 16 : (transfers_done < 1400) ? 87 : 0;
         if (!go && fragments_pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_payload <= fragments_pending.pop_front();
            go = 1'b1;
         end
         start <= go;
      end
   end

   // Monitor: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pixels_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %p", rsp_payload);
         end else begin
            want = pixels_expected.pop_front();
            if (rsp_payload !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   function automatic req_type make_cmd(logic [1:0] op, logic [23:0] u, logic [23:0] v,
                                        logic [7:0] x, logic [7:0] y, logic [31:0] d);
      req_type c;
      c.operation = op;
      c.tex_u = u;
      c.tex_v = v;
      c.pixel_x = x;
      c.pixel_y = y;
      c.fragment_depth = d;
      return c;
   endfunction

   // Mostly plots and reads packed into a small corner so depth tests
   // collide, with some full-range pixels and depths.
   function automatic req_type random_cmd();
      req_type c;
      int      pick;
      c.tex_u = 24'($urandom);
      c.tex_v = 24'($urandom);
      pick = $urandom_range(0, 99);
      c.operation = (pick < 62) ? OP_PLOT : (pick < 95) ? OP_READ : OP_SPARE;
      if ($urandom_range(0, 4) == 0) begin
         c.pixel_x = 8'($urandom);
         c.pixel_y = 8'($urandom);
      end else begin
         c.pixel_x = 8'($urandom_range(0, 5));
         c.pixel_y = 8'($urandom_range(0, 5));
      end
      pick = $urandom_range(0, 19);
      c.fragment_depth = (pick == 0) ? 32'hFFFF_FFFF :
                         (pick < 8)  ? 32'($urandom_range(0, 4095)) : 32'($urandom);
      return c;
   endfunction

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (fragments_pending.size() != 0 || start || pixels_expected.size() != 0);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ATTENUATION: fade_gain    = data[15:0];
         CSR_LIGHT:       light_shade  = data[15:0];
         CSR_DARK:        dark_shade   = data[15:0];
         default:         checker_cell = data;
      endcase
   endtask

   task automatic write_settings(logic [15:0] a, logic [15:0] l, logic [15:0] k,
                                 logic [23:0] c);
      write_csr(CSR_ATTENUATION, a);
      write_csr(CSR_LIGHT, l);
      write_csr(CSR_DARK, k);
      write_csr(CSR_CELL, c);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_ATTENUATION;
      csr_wdata   = '0;
      transfers_done = 0;
      mismatches     = 0;
      fade_gain    = ATTENUATION_RESET;
      light_shade  = LIGHT_RESET;
      dark_shade   = DARK_RESET;
      checker_cell = CELL_RESET;
      clear_shadow_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset settings: strict compare, the top
      // depth, the frame corners, the spare opcode and a clear.
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'd0, 24'd0, 8'd0, 8'd0, 32'd100));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'd9000, 24'd0, 8'd0, 8'd0, 32'd100));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'd0, 24'd0, 8'd0, 8'd0, 32'd99));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'd5, 24'd5, 8'd1, 8'd1, 32'hFFFF_FFFF));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 8'd255,
                                           32'd0));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'hFFFFFF, 24'd0, 8'd255, 8'd0,
                                           32'hFFFF_FFFE));
      fragments_pending.push_back(make_cmd(OP_READ, 24'd0, 24'd0, 8'd255, 8'd255, 32'd0));
      fragments_pending.push_back(make_cmd(OP_SPARE, 24'hFFFFFF, 24'hFFFFFF, 8'd0, 8'd0,
                                           32'hFFFF_FFFF));
      fragments_pending.push_back(make_cmd(OP_READ, 24'd0, 24'd0, 8'd7, 8'd3, 32'd0));
      fragments_pending.push_back(make_cmd(OP_CLEAR, 24'd0, 24'd0, 8'd0, 8'd0, 32'd0));
      fragments_pending.push_back(make_cmd(OP_READ, 24'd0, 24'd0, 8'd0, 8'd0, 32'd0));
      fragments_pending.push_back(make_cmd(OP_PLOT, 24'd0, 24'd0, 8'd0, 8'd0, 32'd0));
      // Hold the sender until every result has arrived.
      wait_drained();

      // Each setting gets a clear and then a batch of random traffic.
      for (int s = 0; s < 5; s++) begin
         case (s)
            0: write_settings(16'd0, 16'hFFFF, 16'd0, 24'd1);
            1: write_settings(16'hFFFF, 16'd0, 16'hFFFF, 24'hFFFFFF);
            2: write_settings(16'd1, 16'hFFFF, 16'hFFFF, 24'd0);
            3: write_settings(16'($urandom), 16'($urandom), 16'($urandom),
                              24'($urandom_range(1, 1 << 18)));
            default: write_settings(ATTENUATION_RESET, LIGHT_RESET, DARK_RESET, CELL_RESET);
         endcase
         fragments_pending.push_back(make_cmd(OP_CLEAR, 24'd0, 24'd0, 8'd0, 8'd0, 32'd0));
         for (int n = 0; n < 400; n++)
            fragments_pending.push_back(random_cmd());
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (mismatches == 0 && pixels_expected.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: well beyond the startup sweep, six clears and every plot.
   initial begin
      #(12 * 3_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/dtcs_pkg.sv
hw/rtl/dtcs_ctrl.sv
hw/rtl/dtcs_datapath.sv
hw/rtl/depth_tested_checker_shader.sv
hw/rtl/dtcs_checker.sv
bench/depth_tested_checker_shader_tb.sv
